### rtl/lts_pkg.sv
package lts_pkg;

    localparam int MaxActions = 6;
    localparam int NumCand    = 6;
    localparam int CntW       = $clog2(MaxActions + 1);
    localparam int IdxW       = (MaxActions > 1) ? $clog2(MaxActions) : 1;
    localparam int QDepth     = 2;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_A   = 2'd1;
    localparam logic [1:0] MODE_B   = 2'd2;

    typedef enum logic [3:0] {
        ACT_BRAKE_ON   = 4'd0,
        ACT_BRAKE_OFF  = 4'd1,
        ACT_LEFT_ON    = 4'd2,
        ACT_LEFT_OFF   = 4'd3,
        ACT_RIGHT_ON   = 4'd4,
        ACT_RIGHT_OFF  = 4'd5,
        ACT_LOW_ON     = 4'd6,
        ACT_LOW_OFF    = 4'd7,
        ACT_HIGH_ON    = 4'd8,
        ACT_HIGH_OFF   = 4'd9,
        ACT_MARKER_ON  = 4'd10,
        ACT_MARKER_OFF = 4'd11
    } action_t;

    typedef struct packed {
        action_t [MaxActions-1:0] codes;
        logic    [CntW-1:0]       count;
    } act_list_t;

    typedef struct packed {
        logic       off_v;
        logic       off_is_a;
        logic       on_v;
        logic       on_is_a;
        logic [1:0] new_mode;
    } pair_res_t;

    // exclusive pair (turn side or beam), side a has priority
    function automatic pair_res_t pair_step(logic [1:0] mode, logic want_a, logic want_b);
        pair_res_t r;
        r = '0;
        if (want_a)
        begin
            r.off_v    = (mode == MODE_B);
            r.off_is_a = 1'b0;
            r.on_v     = (mode != MODE_A);
            r.on_is_a  = 1'b1;
            r.new_mode = MODE_A;
        end
        else if (want_b)
        begin
            r.off_v    = (mode == MODE_A);
            r.off_is_a = 1'b1;
            r.on_v     = (mode != MODE_B);
            r.on_is_a  = 1'b0;
            r.new_mode = MODE_B;
        end
        else
        begin
            r.off_v    = (mode == MODE_A) || (mode == MODE_B);
            r.off_is_a = (mode == MODE_A);
            r.new_mode = r.off_v ? MODE_OFF : mode;
        end
        return r;
    endfunction

endpackage

### rtl/lts_if.sv
interface lts_req_if;
    logic valid;
    logic ready;
    logic brake_request;
    logic left_turn_request;
    logic right_turn_request;
    logic low_beam_request;
    logic high_beam_request;
    logic marker_request;

    modport source (output valid, output brake_request, output left_turn_request,
                    output right_turn_request, output low_beam_request,
                    output high_beam_request, output marker_request, input ready);
    modport sink (input valid, input brake_request, input left_turn_request,
                  input right_turn_request, input low_beam_request,
                  input high_beam_request, input marker_request, output ready);
endinterface

interface lts_act_if;
    logic       valid;
    logic       ready;
    logic [3:0] action_code;
    logic       last_action;

    modport source (output valid, output action_code, output last_action, input ready);
    modport sink (input valid, input action_code, input last_action, output ready);
endinterface

### rtl/lts_front.sv
module lts_front (
    input  logic              clk,
    input  logic              rst_n,
    lts_req_if.sink           req,
    output lts_pkg::act_list_t list,
    output logic              push,
    input  logic              full
);
    import lts_pkg::*;

    logic       brake_lit_reg;
    logic       marker_lit_reg;
    logic [1:0] turn_mode_reg;
    logic [1:0] beam_mode_reg;
    logic       accept;
    pair_res_t  turn_r;
    pair_res_t  beam_r;
    logic    [NumCand-1:0] cand_v;
    action_t [NumCand-1:0] cand_c;
    logic    [CntW-1:0]    pos;

    assign req.ready = !full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        turn_r = pair_step(turn_mode_reg, req.left_turn_request, req.right_turn_request);
        beam_r = pair_step(beam_mode_reg, req.low_beam_request, req.high_beam_request);

        cand_v[0] = req.brake_request != brake_lit_reg;
        cand_c[0] = req.brake_request ? ACT_BRAKE_ON : ACT_BRAKE_OFF;
        cand_v[1] = turn_r.off_v;
        cand_c[1] = turn_r.off_is_a ? ACT_LEFT_OFF : ACT_RIGHT_OFF;
        cand_v[2] = turn_r.on_v;
        cand_c[2] = turn_r.on_is_a ? ACT_LEFT_ON : ACT_RIGHT_ON;
        cand_v[3] = beam_r.off_v;
        cand_c[3] = beam_r.off_is_a ? ACT_LOW_OFF : ACT_HIGH_OFF;
        cand_v[4] = beam_r.on_v;
        cand_c[4] = beam_r.on_is_a ? ACT_LOW_ON : ACT_HIGH_ON;
        cand_v[5] = req.marker_request != marker_lit_reg;
        cand_c[5] = req.marker_request ? ACT_MARKER_ON : ACT_MARKER_OFF;

        // pack in order, drop anything past the list length
        list = '0;
        pos  = '0;
        for (int k = 0; k < NumCand; k++)
        begin
            if (cand_v[k] && (pos < CntW'(MaxActions)))
            begin
                list.codes[pos[IdxW-1:0]] = cand_c[k];
                pos = pos + CntW'(1);
            end
        end
        list.count = pos;
    end

    assign push = accept && (pos != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_lit_reg  <= 1'b0;
            marker_lit_reg <= 1'b0;
            turn_mode_reg  <= MODE_OFF;
            beam_mode_reg  <= MODE_OFF;
        end
        else if (accept)
        begin
            brake_lit_reg  <= req.brake_request;
            marker_lit_reg <= req.marker_request;
            turn_mode_reg  <= turn_r.new_mode;
            beam_mode_reg  <= beam_r.new_mode;
        end
    end

endmodule

### rtl/lts_queue.sv
module lts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lts_pkg::act_list_t wr_list,
    output logic               full,
    input  logic               pop,
    output lts_pkg::act_list_t rd_list,
    output logic               empty
);
    import lts_pkg::*;

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int FillW = $clog2(QDepth + 1);

    act_list_t             mem_reg [QDepth];
    logic [PtrW-1:0]       wr_ptr_reg;
    logic [PtrW-1:0]       rd_ptr_reg;
    logic [FillW-1:0]      fill_reg;
    logic [FillW-1:0]      fill_next;

    assign full    = (fill_reg == FillW'(QDepth));
    assign empty   = (fill_reg == '0);
    assign rd_list = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + FillW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FillW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_list;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
        end
    end

endmodule

### rtl/lts_back.sv
module lts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lts_pkg::act_list_t rd_list,
    input  logic               empty,
    output logic               pop,
    lts_act_if.source          act
);
    import lts_pkg::*;

    act_list_t        cur_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [CntW-1:0]  idx_reg;
    logic [CntW-1:0]  idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    action_t          code_reg;
    action_t          code_next;
    logic             last_reg;
    logic             last_next;
    logic             adv;
    logic             at_last;

    assign act.valid       = out_valid_reg;
    assign act.action_code = code_reg;
    assign act.last_action = last_reg;

    assign adv     = !out_valid_reg || act.ready;
    assign at_last = (idx_reg == cur_reg.count - CntW'(1));
    assign pop     = !empty && (!busy_reg || (adv && at_last));

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                code_next = cur_reg.codes[idx_reg[IdxW-1:0]];
                last_next = at_last;
                idx_next  = idx_reg + CntW'(1);
                if (at_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= rd_list;
        end
        code_reg <= code_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/lamp_transition_sequencer.sv
// Lamp transition sequencer.
// req (sink): one target lamp word per handshake with the six request flags.
// act (source): one channel action per word, action_code and last_action;
//   last_action marks the final action produced for a request.
// The front stage holds the lamp state and turns each request into an
// ordered action list in the cycle it is accepted; requests needing no
// change produce no words. Lists wait in a two-entry queue; the back stage
// plays one action per cycle into an output register while act.ready is high.
// Lists pass the queue and the back stage's list register; each action is then
// registered into the output word. Throughput: one action word per cycle on
// act while act.ready is high; a request has up to six actions. req.ready is
// high whenever the queue has room, so requests are taken back to back.
// Reset: all lamps off, queue and output empty, no clearing pass.
// Stall: when act.ready is low the output word holds; the queue fills and
// req.ready drops once two lists are waiting.
module lamp_transition_sequencer (
    input  logic      clk,
    input  logic      rst_n,
    lts_req_if.sink   req,
    lts_act_if.source act
);
    import lts_pkg::*;

    act_list_t wr_list;
    act_list_t rd_list;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    lts_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .list  (wr_list),
        .push  (push),
        .full  (full)
    );

    lts_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_list (wr_list),
        .full    (full),
        .pop     (pop),
        .rd_list (rd_list),
        .empty   (empty)
    );

    lts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_list (rd_list),
        .empty   (empty),
        .pop     (pop),
        .act     (act)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("queue underflow");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        act.valid |-> (act.action_code <= ACT_MARKER_OFF)) else $error("bad action code");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (wr_list.count != '0)) else $error("empty list queued");
`endif

endmodule
